FILE: rtl/core/prf_pkg.sv
// Shared types, constants and helpers for the page replacement block.
// Used by prf_ctrl, prf_dpath and page_replacement_fifo_lru_top; depends on nothing.
package prf_pkg;

   // Table geometry.
   localparam int NUM_FRAMES = 16;
   localparam int PAGE_BITS  = 20;
   localparam int STAMP_BITS = 32;
   localparam int CNT_BITS   = 32;
   localparam int IDX_W      = $clog2(NUM_FRAMES);
   localparam int FILL_W     = $clog2(NUM_FRAMES + 1);
   localparam int FIDX_W     = 4;
   localparam int FRAMES_W   = 5;

   // Register port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Operation codes.
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Replacement policies.
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // Register index, taken from address bit 2.
   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_FRAMES = 1'b1;

   // Reset values of the registers.
   localparam logic                POLICY_RESET = POLICY_LRU;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(NUM_FRAMES);

   // One request beat.
   typedef struct packed {
      logic                 operation;
      logic [PAGE_BITS-1:0] page_number;
      logic                 is_write;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic                 hit;
      logic                 fault;
      logic [FIDX_W-1:0]    frame_index;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
      logic                 evicted_dirty;
      logic [CNT_BITS-1:0]  event_count;
      logic [CNT_BITS-1:0]  read_count;
      logic [CNT_BITS-1:0]  write_count;
      logic [CNT_BITS-1:0]  fault_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;
      logic match;
   } status_type;

   // Saturating increment of an event counter.
   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

FILE: rtl/core/prf_ctrl.sv
// Sequencer for the page replacement block: accept, frame scan, table update.
// Depends on prf_pkg for the command and status types.
module prf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  prf_pkg::status_type status,
   output logic                busy,
   output prf_pkg::cmd_type    cmd
);
   import prf_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state: the scan ends on the first match or after the last filled frame.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_end || status.match) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands decode from the state; the load also needs start.
   assign busy       = (state_ff != S_IDLE);
   assign cmd.load   = (state_ff == S_IDLE) && start;
   assign cmd.scan   = (state_ff == S_SCAN);
   assign cmd.update = (state_ff == S_UPDATE);

endmodule

FILE: rtl/core/prf_dpath.sv
// Datapath of the page replacement block: frame table, scan pointer, victim
// choice, counters and the result register. Depends on prf_pkg.
module prf_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  prf_pkg::cmd_type              cmd,
   input  prf_pkg::req_type              req_data,
   input  logic                          policy,
   input  logic [prf_pkg::FRAMES_W-1:0]  frames_in_use,
   output prf_pkg::status_type           status,
   output logic                          rsp_valid,
   output prf_pkg::rsp_type              rsp_data
);
   import prf_pkg::*;

   // Frame table. Pages and stamps are only used inside the filled range.
   logic [PAGE_BITS-1:0]  page_mem  [NUM_FRAMES];
   logic [STAMP_BITS-1:0] stamp_mem [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] dirty_ff, dirty_in;

   logic [FILL_W-1:0]     filled_ff, filled_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [STAMP_BITS-1:0] time_ff, time_in;
   logic [CNT_BITS-1:0]   events_ff, events_in;
   logic [CNT_BITS-1:0]   reads_ff, reads_in;
   logic [CNT_BITS-1:0]   writes_ff, writes_in;
   logic [CNT_BITS-1:0]   faults_ff, faults_in;

   // Per-item working registers.
   req_type               req_ff, req_in;
   logic [FILL_W-1:0]     idx_ff, idx_in;
   logic                  hit_ff, hit_in;
   logic [STAMP_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [PAGE_BITS-1:0]  page_rd_ff;
   logic [STAMP_BITS-1:0] stamp_rd_ff;

   logic [IDX_W-1:0]      rd_idx;
   logic [PAGE_BITS-1:0]  page_rd;
   logic [STAMP_BITS-1:0] stamp_rd;
   logic                  dirty_rd;
   logic [FILL_W-1:0]     limit;
   logic [IDX_W-1:0]      head_eff;
   logic [FILL_W-1:0]     head_next;
   logic [IDX_W-1:0]      head_wrap;
   logic [FILL_W-1:0]     miss_slot;
   logic                  is_access;
   logic                  has_free;

   // One read port, addressed by the scan pointer; in the update cycle it
   // holds the chosen frame. The table read is registered at the next pointer
   // value, so the read data belongs to the frame at the current pointer.
   assign rd_idx   = idx_ff[IDX_W-1:0];
   assign page_rd  = page_rd_ff;
   assign stamp_rd = stamp_rd_ff;
   assign dirty_rd = dirty_ff[rd_idx];

   assign is_access = (req_ff.operation == OP_ACCESS);

   // Usable frame count: zero acts as one, large values clip to the table size.
   always_comb begin
      if (frames_in_use == '0) begin
         limit = FILL_W'(1);
      end else if (int'(frames_in_use) > NUM_FRAMES) begin
         limit = FILL_W'(NUM_FRAMES);
      end else begin
         limit = FILL_W'(frames_in_use);
      end
   end

   // Round-robin head, folded back when it lies beyond the usable frames.
   assign head_eff  = (FILL_W'(head_ff) >= limit) ? '0 : head_ff;
   assign head_next = FILL_W'(head_eff) + 1'b1;
   assign head_wrap = (head_next >= limit) ? '0 : head_next[IDX_W-1:0];
   assign has_free  = (filled_ff < limit);

   // Frame to load on a miss.
   always_comb begin
      if (has_free) begin
         miss_slot = filled_ff;
      end else if (policy == POLICY_LRU) begin
         miss_slot = FILL_W'(best_idx_ff);
      end else begin
         miss_slot = FILL_W'(head_eff);
      end
   end

   assign status.scan_end = (idx_ff == filled_ff);
   assign status.match    = is_access && !status.scan_end
                            && (page_rd == req_ff.page_number);

   // Next values of all registers.
   always_comb begin
      dirty_in     = dirty_ff;
      filled_in    = filled_ff;
      head_in      = head_ff;
      time_in      = time_ff;
      events_in    = events_ff;
      reads_in     = reads_ff;
      writes_in    = writes_ff;
      faults_in    = faults_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      // Take the request and start the scan at frame zero.
      if (cmd.load) begin
         req_in = req_data;
         idx_in = '0;
         hit_in = 1'b0;
      end

      // One frame per cycle: look for the page, track the oldest stamp,
      // or count dirty frames for a flush.
      if (cmd.scan) begin
         if (status.scan_end) begin
            if (is_access) idx_in = miss_slot;
         end else if (status.match) begin
            hit_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            if (is_access) begin
               if ((idx_ff < limit) && ((idx_ff == '0) || (stamp_rd < best_ff))) begin
                  best_in     = stamp_rd;
                  best_idx_in = rd_idx;
               end
            end else if (dirty_rd) begin
               writes_in = sat_inc(writes_ff);
            end
         end
      end

      // Apply the item to the table and build the result beat.
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (!is_access) begin
            dirty_in  = '0;
            filled_in = '0;
         end else begin
            events_in = sat_inc(events_ff);
            if (hit_ff) begin
               if (req_ff.is_write) dirty_in[rd_idx] = 1'b1;
            end else begin
               faults_in = sat_inc(faults_ff);
               reads_in  = sat_inc(reads_ff);
               if (has_free) begin
                  filled_in = filled_ff + 1'b1;
               end else begin
                  rsp_in.evicted_valid = 1'b1;
                  rsp_in.evicted_page  = page_rd;
                  rsp_in.evicted_dirty = dirty_rd;
                  if (dirty_rd) writes_in = sat_inc(writes_ff);
               end
               dirty_in[rd_idx] = req_ff.is_write;
               head_in = (policy == POLICY_FIFO) ? head_wrap : head_eff;
            end
            if (time_ff != '1) time_in = time_ff + 1'b1;
            rsp_in.hit         = hit_ff;
            rsp_in.fault       = !hit_ff;
            rsp_in.frame_index = FIDX_W'(rd_idx);
         end
         rsp_in.event_count = events_in;
         rsp_in.read_count  = reads_in;
         rsp_in.write_count = writes_in;
         rsp_in.fault_count = faults_in;
      end
   end

   // Control state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff     <= '0;
         filled_ff    <= '0;
         head_ff      <= '0;
         time_ff      <= STAMP_BITS'(1);
         events_ff    <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         faults_ff    <= '0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dirty_ff     <= dirty_in;
         filled_ff    <= filled_in;
         head_ff      <= head_in;
         time_ff      <= time_in;
         events_ff    <= events_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         faults_ff    <= faults_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   // Frame table writes: stamp on every access, page only on a load.
   always_ff @(posedge clock) begin
      if (cmd.update && is_access) begin
         stamp_mem[rd_idx] <= time_ff;
         if (!hit_ff) page_mem[rd_idx] <= req_ff.page_number;
      end
   end

   // Frame table read at the pointer of the next cycle. Writes only happen in
   // the update cycle, and the next item's scan reads the table again first.
   always_ff @(posedge clock) begin
      page_rd_ff  <= page_mem[idx_in[IDX_W-1:0]];
      stamp_rd_ff <= stamp_mem[idx_in[IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/page_replacement_fifo_lru_top.sv
// Top level of the FIFO/LRU page frame table: register port, controller and datapath.
// Depends on prf_pkg, prf_ctrl and prf_dpath.
//
//   Channel   Ports                                  Handshake
//   request   start, busy, req_data                  beat taken when start && !busy
//   result    rsp_valid, rsp_data                    one-cycle strobe, no back-pressure
//   config    psel, penable, pwrite, paddr, pwdata,  write at access phase, pready = 1
//             prdata, pready
//
// An item passes an accept step, a scan of the filled frames, one frame a
// cycle, up to the first match or the last filled frame, and an update step;
// no new request is taken while busy is high. The result beat appears the
// cycle after the update, when busy has already dropped. Reset empties the
// table and clears the counters at once; there is no clearing pass. The
// receiver cannot stall, so the block never waits on it.
module page_replacement_fifo_lru_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  prf_pkg::req_type                req_data,
   output logic                            busy,
   output logic                            rsp_valid,
   output prf_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [prf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [prf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [prf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import prf_pkg::*;

   logic                csr_policy_ff;
   logic [FRAMES_W-1:0] csr_frames_ff;
   logic                csr_write;
   logic                csr_sel;
   cmd_type             cmd;
   status_type          status;

   // Register port: writes complete in the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_policy_ff <= POLICY_RESET;
         csr_frames_ff <= FRAMES_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_POLICY: csr_policy_ff <= pwdata[0];
            REG_FRAMES: csr_frames_ff <= pwdata[FRAMES_W-1:0];
            default:    csr_policy_ff <= csr_policy_ff;
         endcase
      end
   end

   // Read data.
   always_comb begin
      unique case (csr_sel)
         REG_POLICY: prdata = CSR_DATA_W'(csr_policy_ff);
         REG_FRAMES: prdata = CSR_DATA_W'(csr_frames_ff);
         default:    prdata = '0;
      endcase
   end

   prf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   prf_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data      (req_data),
      .policy        (csr_policy_ff),
      .frames_in_use (csr_frames_ff),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

endmodule
